FILE: rtl/rlmd_pkg.sv
// Shared constants, codes and controller/datapath handshake types for the ring list.
package rlmd_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_VALUE_BITS = 32;

  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 5;

  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = OPCODE_W'(0);
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = OPCODE_W'(1);
  localparam logic [OPCODE_W-1:0] OP_REMOVE     = OPCODE_W'(2);
  localparam logic [OPCODE_W-1:0] OP_CLEAR      = OPCODE_W'(3);

  localparam logic [STATUS_W-1:0] ST_DONE    = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_FULL    = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_MISSING = STATUS_W'(2);

  typedef struct packed {
    logic load;
    logic push_front;
    logic push_back;
    logic scan;
    logic shift;
    logic dec;
    logic clear;
    logic rd_first;
    logic rd_last;
    logic cap_first;
    logic set_full;
    logic set_missing;
    logic publish;
  } rlmd_cmd_t;

  typedef struct packed {
    logic full;
    logic more;
    logic match;
    logic pend;
    logic out_free;
  } rlmd_sts_t;

endpackage

FILE: rtl/rlmd_in_if.sv
// Input channel: one list operation per transfer.
interface rlmd_in_if import rlmd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [VALUE_W-1:0]  item_value;

  modport source(output valid, output opcode, output item_value, input ready);
  modport sink(input valid, input opcode, input item_value, output ready);
endinterface

FILE: rtl/rlmd_out_if.sv
// Output channel: one result per operation.
interface rlmd_out_if import rlmd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [LEN_W-1:0]    list_length;
  logic [VALUE_W-1:0]  first_value;
  logic [VALUE_W-1:0]  last_value;

  modport source(output valid, output status, output list_length, output first_value,
                 output last_value, input ready);
  modport sink(input valid, input status, input list_length, input first_value,
               input last_value, output ready);
endinterface

FILE: rtl/rlmd_ctl.sv
// Sequencing state machine for the ring list operations.
module rlmd_ctl import rlmd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [OPCODE_W-1:0] opcode,
  input  rlmd_sts_t           sts,
  output logic                take,
  output rlmd_cmd_t           cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PUSH  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;
  localparam logic [2:0] S_RDF   = 3'd5;
  localparam logic [2:0] S_RDL   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [OPCODE_W-1:0] op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= opcode;
    end
  end

  assign take = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          case (opcode)
            OP_PUSH_FRONT: state_next = S_PUSH;
            OP_PUSH_BACK:  state_next = S_PUSH;
            OP_REMOVE:     state_next = S_SCAN;
            OP_CLEAR:      state_next = S_CLEAR;
            default:       state_next = S_RDF;
          endcase
        end
      end
      S_PUSH: begin
        if (sts.full) begin
          cmd.set_full = 1'b1;
        end else if (op == OP_PUSH_FRONT) begin
          cmd.push_front = 1'b1;
        end else begin
          cmd.push_back = 1'b1;
        end
        state_next = S_RDF;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.match) begin
          state_next = S_SHIFT;
        end else if (!sts.more && !sts.pend) begin
          cmd.set_missing = 1'b1;
          state_next      = S_RDF;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (!sts.more) begin
          cmd.dec    = 1'b1;
          state_next = S_RDF;
        end
      end
      S_CLEAR: begin
        cmd.clear  = 1'b1;
        state_next = S_RDF;
      end
      S_RDF: begin
        cmd.rd_first = 1'b1;
        state_next   = S_RDL;
      end
      S_RDL: begin
        cmd.rd_last   = 1'b1;
        cmd.cap_first = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/rlmd_dp.sv
// Datapath: ring store, head and count, scan and shift pointers, result register.
module rlmd_dp import rlmd_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  rlmd_cmd_t           cmd,
  input  logic [VALUE_W-1:0]  item_value,
  input  logic                out_ready,
  output rlmd_sts_t           sts,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [LEN_W-1:0]    out_len,
  output logic [VALUE_W-1:0]  out_first,
  output logic [VALUE_W-1:0]  out_last
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW:0]   CAP_S = (IW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [VALUE_BITS-1:0] mem [CAPACITY];

  logic [IW-1:0]         head;
  logic [CW-1:0]         count;
  logic [CW-1:0]         pos;
  logic [CW-1:0]         pend_pos;
  logic                  pend;
  logic [VALUE_BITS-1:0] value;
  logic [VALUE_BITS-1:0] rdata;
  logic [VALUE_BITS-1:0] first;
  logic [STATUS_W-1:0]   status_q;

  logic                  rd_en;
  logic [IW-1:0]         raddr;
  logic                  wr_en;
  logic [IW-1:0]         waddr;
  logic [VALUE_BITS-1:0] wdata;
  logic [IW-1:0]         head_dec;
  logic                  empty;
  logic                  match;
  logic                  more;

  logic [VALUE_BITS+VALUE_W-1:0] in_ext;
  logic [VALUE_BITS+VALUE_W-1:0] first_ext;
  logic [VALUE_BITS+VALUE_W-1:0] last_ext;
  logic [CW+LEN_W-1:0]           len_ext;

  // Ring position to store slot; both operands are below the capacity.
  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                            input logic [CW-1:0] p);
    logic [IW:0] sum;
    begin
      sum = {1'b0, base} + {1'b0, p[IW-1:0]};
      if (sum >= CAP_S) begin
        sum = sum - CAP_S;
      end
      return sum[IW-1:0];
    end
  endfunction

  assign in_ext    = {{VALUE_BITS{1'b0}}, item_value};
  assign first_ext = {{VALUE_W{1'b0}}, first};
  assign last_ext  = {{VALUE_W{1'b0}}, rdata};
  assign len_ext   = {{LEN_W{1'b0}}, count};

  assign empty    = (count == '0);
  assign more     = (pos < count);
  assign match    = pend && (rdata == value);
  assign head_dec = (head == '0) ? IW'(CAPACITY - 1) : head - IW'(1);

  assign sts.full     = (count == CAP_C);
  assign sts.more     = more;
  assign sts.match    = match;
  assign sts.pend     = pend;
  assign sts.out_free = !out_valid || out_ready;

  always_comb begin
    rd_en = 1'b0;
    raddr = slot_of(head, pos);
    wr_en = 1'b0;
    waddr = slot_of(head, pend_pos - CW'(1));
    wdata = rdata;
    if (cmd.scan) begin
      rd_en = more && !match;
    end
    if (cmd.shift) begin
      rd_en = more;
      wr_en = pend;
    end
    if (cmd.push_front) begin
      wr_en = 1'b1;
      waddr = head_dec;
      wdata = value;
    end
    if (cmd.push_back) begin
      wr_en = 1'b1;
      waddr = slot_of(head, count);
      wdata = value;
    end
    if (cmd.rd_first) begin
      rd_en = 1'b1;
      raddr = head;
    end
    if (cmd.rd_last) begin
      rd_en = 1'b1;
      raddr = slot_of(head, count - CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      pos       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= rd_en && (cmd.scan || cmd.shift);
      if (cmd.load) begin
        pos <= '0;
      end else if (rd_en && (cmd.scan || cmd.shift)) begin
        pos <= pos + CW'(1);
      end
      if (cmd.push_front) begin
        head  <= head_dec;
        count <= count + CW'(1);
      end else if (cmd.push_back) begin
        count <= count + CW'(1);
      end else if (cmd.dec) begin
        count <= count - CW'(1);
      end else if (cmd.clear) begin
        head  <= '0;
        count <= '0;
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      pend_pos <= pos;
    end
    if (cmd.load) begin
      value    <= in_ext[VALUE_BITS-1:0];
      status_q <= ST_DONE;
    end else if (cmd.set_full) begin
      status_q <= ST_FULL;
    end else if (cmd.set_missing) begin
      status_q <= ST_MISSING;
    end
    if (cmd.cap_first) begin
      first <= rdata;
    end
    if (cmd.publish) begin
      out_status <= status_q;
      out_len    <= len_ext[LEN_W-1:0];
      out_first  <= empty ? '0 : first_ext[VALUE_W-1:0];
      out_last   <= empty ? '0 : last_ext[VALUE_W-1:0];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CAP_C)
    else $error("entry count above capacity");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.push_front || cmd.push_back) |-> !sts.full)
    else $error("insert issued into a full list");

  a_shift_addr: assert property (@(posedge clk) disable iff (rst)
    (cmd.shift && rd_en && wr_en) |-> (raddr != waddr))
    else $error("shift reads and writes the same slot");

endmodule

FILE: rtl/ring_list_with_match_delete.sv
// Top level of the bounded ring list with insert, match-delete, clear and query.
//
//   channel  modport  payload                                        meaning
//   item     sink     opcode, item_value                             one list operation
//   result   source   status, list_length, first_value, last_value   state after it
//
// A removal scans the list one entry per cycle through the single registered
// read port of the store, then closes the gap one entry per cycle. Reset is
// synchronous and empties the list; store contents are not cleared. A new item
// is taken while a finished result still waits; its own result is held back
// until the output register frees up.
module ring_list_with_match_delete import rlmd_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  rlmd_in_if.sink     item,
  rlmd_out_if.source  result
);

  rlmd_cmd_t cmd;
  rlmd_sts_t sts;
  logic      take;
  logic      accept;

  // An operation transfer happens only while the controller is idle.
  assign item.ready = take;
  assign accept     = item.valid && take;

  rlmd_ctl u_ctl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .opcode (item.opcode),
    .sts    (sts),
    .take   (take),
    .cmd    (cmd)
  );

  // The datapath owns the store, the ring pointers and the result register.
  rlmd_dp #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .item_value (item.item_value),
    .out_ready  (result.ready),
    .sts        (sts),
    .out_valid  (result.valid),
    .out_status (result.status),
    .out_len    (result.list_length),
    .out_first  (result.first_value),
    .out_last   (result.last_value)
  );

endmodule
